### design/bqf_pkg.sv
package bqf_pkg;
   localparam int CoefWidth   = 24;
   localparam int GainWidth   = 16;
   localparam int SampleWidth = 16;
   localparam int HistWidth   = 32;
   // 16x16 product is 32 bits, >>4 leaves 28; keep 32 for history
   localparam int AccWidth    = 59;  // five 24x32 products, signed, with growth
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = 24;

   localparam logic [CsrIdxWidth-1:0] RegFf0  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegFf1  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegFf2  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegFb1  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegFb2  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegGain = 3'd5;

   localparam logic signed [CoefWidth-1:0] Ff0Reset  = 24'sd1048576;
   localparam logic [GainWidth-1:0]        GainReset = 16'd4096;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // control from sequencer to multiply unit
   typedef struct packed {
      logic load;   // load operands, clear product
      logic step;   // one multiplier bit
   } mul_ctl_type;
endpackage

### design/bqf_serial_mul.sv
// Signed shift-add multiplier, one bit of the multiplier operand per cycle in which ctl.step is set.
// Multiplicand a (signed, WA bits), multiplier b (signed, WB bits).
module bqf_serial_mul import bqf_pkg::*; #(
   parameter int WA = 32,
   parameter int WB = 24
) (
   input  logic                   clock,
   input  mul_ctl_type            ctl,
   input  logic signed [WA-1:0]   a,
   input  logic signed [WB-1:0]   b,
   input  logic [$clog2(WB)-1:0]  bit_idx,
   output logic signed [WA+WB-1:0] prod
);
   logic signed [WA+WB-1:0] prod_ff, prod_in;
   logic signed [WA-1:0]    a_ff, a_in;
   logic [WB-1:0]           b_ff, b_in;
   logic signed [WA+WB-1:0] term;

   always_comb begin
      term = {{WB{a_ff[WA-1]}}, a_ff} <<< bit_idx;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      if (ctl.load) begin
         a_in = a;
         b_in = b;
         prod_in = '0;
      end else if (ctl.step && b_ff[bit_idx]) begin
         // sign bit of b carries negative weight
         if (bit_idx == $clog2(WB)'(WB-1))
            prod_in = prod_ff - term;
         else
            prod_in = prod_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

### design/biquad_iir_filter.sv
// Direct-form-I biquad on signed 16-bit audio words.
// req_ channel: one input word per transfer, tdata = sample_in.
// rsp_ channel: one output word per input, tdata = sample_out.
// csr_ port: write-only; index 0..4 = ff0,ff1,ff2,fb1,fb2 (Q4.20), 5 = gain
//   (Q4.12). A coefficient write clears the four history registers.
// One word at a time: the input is scaled by a gain pass through ST_MUL and
//   ST_FIN, then the five products are formed with one bit-serial multiplier,
//   each a pass through ST_MUL and ST_FIN, and ST_OUT writes the result;
//   the shared serial multiplier sets the time from accept to rsp_tvalid.
// req_tready is high only while idle. The result is held in an output
//   register until rsp_tready; the next word is accepted in that same cycle.
// Reset: coefficients to ff0 = 1.0, others 0, gain 1.0, history zero,
//   no pending output.
module biquad_iir_filter import bqf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SampleWidth-1:0] req_tdata,  // [15:0] sample_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SampleWidth-1:0] rsp_tdata,  // [15:0] sample_out
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_idx,
   input  logic [CsrWidth-1:0]    csr_wdata
);
   localparam int PW = HistWidth + CoefWidth;  // 56-bit product
   localparam int BW = $clog2(CoefWidth);

   // coefficient registers
   logic signed [CoefWidth-1:0] coef_ff [5];
   logic signed [CoefWidth-1:0] coef_in [5];
   logic [GainWidth-1:0]        gain_ff, gain_in;

   // history, Q24.8
   logic signed [HistWidth-1:0] xin1_ff, xin2_ff, yo1_ff, yo2_ff;
   logic signed [HistWidth-1:0] xin1_in, xin2_in, yo1_in, yo2_in;
   logic signed [HistWidth-1:0] x_ff, x_in;      // current scaled input

   state_type                   state_ff, state_in;
   logic [2:0]                  term_ff, term_in;  // product index 0..4, 5 = gain
   logic [BW-1:0]               bit_ff, bit_in;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic                        ovalid_ff, ovalid_in;
   logic [SampleWidth-1:0]      odata_ff, odata_in;

   mul_ctl_type                 mctl;
   logic signed [HistWidth-1:0] ma;
   logic signed [CoefWidth-1:0] mb;
   logic signed [PW-1:0]        prod;
   logic                        coef_wr;

   // operand select for the shared multiplier
   always_comb begin
      ma = x_ff;
      mb = coef_ff[0];
      case (term_in)
         3'd0: begin ma = x_in;   mb = coef_ff[0]; end
         3'd1: begin ma = xin1_ff; mb = coef_ff[1]; end
         3'd2: begin ma = xin2_ff; mb = coef_ff[2]; end
         3'd3: begin ma = yo1_ff;  mb = coef_ff[3]; end
         3'd4: begin ma = yo2_ff;  mb = coef_ff[4]; end
         // gain pass: sample times gain (gain zero-extended, so positive)
         default: begin
            ma = HistWidth'($signed(req_tdata));
            mb = CoefWidth'({1'b0, gain_ff});
         end
      endcase
   end

   bqf_serial_mul #(.WA(HistWidth), .WB(CoefWidth)) u_mul (
      .clock  (clock),
      .ctl    (mctl),
      .a      (ma),
      .b      (mb),
      .bit_idx(bit_ff),
      .prod   (prod)
   );

   assign coef_wr = csr_we && (csr_idx <= RegFb2);

   logic signed [AccWidth-1:0] acc_next;
   logic signed [AccWidth-1:0] yfull;
   logic signed [HistWidth-1:0] ysat;
   logic signed [HistWidth-1:0] ytrunc;

   always_comb begin
      for (int i = 0; i < 5; i++) coef_in[i] = coef_ff[i];
      gain_in = gain_ff;
      if (csr_we) begin
         unique case (csr_idx)
            RegFf0, RegFf1, RegFf2, RegFb1, RegFb2:
               coef_in[csr_idx] = $signed(csr_wdata);
            RegGain: gain_in = csr_wdata[GainWidth-1:0];
            default: ;
         endcase
      end

      state_in  = state_ff;
      term_in   = term_ff;
      bit_in    = bit_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      xin1_in   = xin1_ff;
      xin2_in   = xin2_ff;
      yo1_in    = yo1_ff;
      yo2_in    = yo2_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      mctl      = '0;

      // products with a negative sign in the sum
      if (term_ff == 3'd3 || term_ff == 3'd4)
         acc_next = acc_ff - AccWidth'(prod);
      else
         acc_next = acc_ff + AccWidth'(prod);

      // ST_OUT: acc_ff already holds the complete sum
      yfull = acc_ff >>> 20;
      if (yfull > AccWidth'(32'sh7fffffff))      ysat = 32'sh7fffffff;
      else if (yfull < -AccWidth'(64'sh80000000)) ysat = 32'sh80000000;
      else                                         ysat = yfull[HistWidth-1:0];
      // divide by 256 toward zero
      ytrunc = (ysat + ((ysat < 0) ? 32'sd255 : 32'sd0)) >>> 8;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (!ovalid_ff || rsp_tready)) begin
               term_in = 3'd5;
               bit_in  = '0;
               mctl.load = 1'b1;
               acc_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mctl.step = 1'b1;
            if ((term_ff == 3'd5 && bit_ff == BW'(GainWidth - 1))
                || bit_ff == BW'(CoefWidth - 1))
               state_in = ST_FIN;
            else
               bit_in = bit_ff + 1'b1;
         end
         ST_FIN: begin
            bit_in = '0;
            if (term_ff == 3'd5) begin
               x_in    = prod[HistWidth+3:4];   // floor(s*g/16)
               term_in = 3'd0;
               mctl.load = 1'b1;
               state_in = ST_MUL;
            end else begin
               acc_in = acc_next;
               if (term_ff == 3'd4) begin
                  state_in = ST_OUT;
               end else begin
                  term_in = term_ff + 1'b1;
                  mctl.load = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_OUT: begin
            xin2_in = xin1_ff;
            xin1_in = x_ff;
            yo2_in  = yo1_ff;
            yo1_in  = ysat;
            if (ytrunc > 32'sd32767)       odata_in = 16'h7fff;
            else if (ytrunc < -32'sd32768) odata_in = 16'h8000;
            else                           odata_in = ytrunc[SampleWidth-1:0];
            ovalid_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (coef_wr) begin
         xin1_in = '0;
         xin2_in = '0;
         yo1_in  = '0;
         yo2_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         coef_ff[0] <= Ff0Reset;
         for (int i = 1; i < 5; i++) coef_ff[i] <= '0;
         gain_ff   <= GainReset;
         xin1_ff   <= '0;
         xin2_ff   <= '0;
         yo1_ff    <= '0;
         yo2_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         for (int i = 0; i < 5; i++) coef_ff[i] <= coef_in[i];
         gain_ff   <= gain_in;
         xin1_ff   <= xin1_in;
         xin2_ff   <= xin2_in;
         yo1_ff    <= yo1_in;
         yo2_ff    <= yo2_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      bit_ff   <= bit_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      odata_ff <= odata_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && (!ovalid_ff || rsp_tready);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
endmodule

### design/bqf_checker.sv
module bqf_checker import bqf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SampleWidth-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");
   a_no_accept_after: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while busy");
   a_no_rsp_soon: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");
endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

### tb/biquad_iir_filter_tb.sv
module biquad_iir_filter_tb;
   import bqf_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SampleWidth-1:0] req_tdata = '0;   // [15:0] sample_in
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SampleWidth-1:0] rsp_tdata;         // [15:0] sample_out
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_idx = '0;
   logic [CsrWidth-1:0]    csr_wdata = '0;

   biquad_iir_filter dut (.*);

   always #5 clock = ~clock;

   // filter state mirror
   logic signed [CoefWidth-1:0] cf_ff0, cf_ff1, cf_ff2, cf_fb1, cf_fb2;
   logic [GainWidth-1:0]        cf_gain;
   logic signed [63:0]          hx1, hx2, hy1, hy2;

   logic [SampleWidth-1:0] sample_queue[$];   // words waiting to be sent
   logic [SampleWidth-1:0] out_expected[$];   // predicted outputs, oldest first

   int    n_errors = 0;
   int    n_sent = 0;
   int    n_checked = 0;
   int    n_cfg = 0;
   int    cycles = 0;
   bit    drained = 1'b0;

   // driver burst control
   int    burst_left = 0;
   int    gap_left = 0;
   // receiver stall pattern
   int    stall_hold = 0;
   bit    long_hold = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      n_errors++;
      $display("ERROR @%0d: %s got %0d expected %0d", cycles, what, got, want);
   endtask

   function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v,
                                                    input int s);
      return v >>> s;   // arithmetic shift is floor for signed values
   endfunction

   // one filter step: returns the predicted output word and updates history
   function automatic logic [SampleWidth-1:0] filter_step(input logic [SampleWidth-1:0] w);
      logic signed [63:0] s, x, acc, y, o;
      s   = 64'(signed'(w));
      x   = floor_shr(s * 64'(cf_gain), 4);
      acc = 64'(cf_ff0) * x + 64'(cf_ff1) * hx1 + 64'(cf_ff2) * hx2
          - 64'(cf_fb1) * hy1 - 64'(cf_fb2) * hy2;
      y   = floor_shr(acc, 20);
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      hx2 = hx1; hx1 = x;
      hy2 = hy1; hy1 = y;
      o = y / 256;   // truncates toward zero
      if (o > 64'sd32767) o = 64'sd32767;
      if (o < -64'sd32768) o = -64'sd32768;
      return o[15:0];
   endfunction

   function automatic void clear_hist();
      hx1 = 0; hx2 = 0; hy1 = 0; hy2 = 0;
   endfunction

   // driver: bursts of random length, random gaps; predict on acceptance
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            out_expected.push_back(filter_step(req_tdata));
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= sample_queue.pop_front();
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 12);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
               end
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
         end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_hold <= $urandom_range(1, 300);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [SampleWidth-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (out_expected.size() == 0)
            report_mismatch("unexpected word", signed'(rsp_tdata), 0);
         else begin
            want = out_expected.pop_front();
            if (rsp_tdata !== want)
               report_mismatch("sample_out", signed'(rsp_tdata), signed'(want));
            n_checked++;
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > 6000000) begin
         $display("TIMEOUT after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [CsrWidth-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_idx <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      // mirror the register update
      case (idx)
         RegFf0:  begin cf_ff0 = val; clear_hist(); end
         RegFf1:  begin cf_ff1 = val; clear_hist(); end
         RegFf2:  begin cf_ff2 = val; clear_hist(); end
         RegFb1:  begin cf_fb1 = val; clear_hist(); end
         RegFb2:  begin cf_fb2 = val; clear_hist(); end
         RegGain: cf_gain = val[GainWidth-1:0];
         default: ;   // unknown index ignored
      endcase
      n_cfg++;
   endtask

   // block until everything queued has been sent and answered, then settle
   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_tvalid || out_expected.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic load_coefs(input logic [CsrWidth-1:0] a0, a1, a2, b1, b2,
                             input logic [CsrWidth-1:0] g);
      csr_write(RegFf0, a0); csr_write(RegFf1, a1); csr_write(RegFf2, a2);
      csr_write(RegFb1, b1); csr_write(RegFb2, b2); csr_write(RegGain, g);
   endtask

   function automatic logic [SampleWidth-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CsrWidth-1:0] rand_coef(input int span);
      logic signed [31:0] v;
      v = $signed($urandom_range(0, 2 * span)) - span;
      return v[CsrWidth-1:0];
   endfunction

   initial begin
      int ph;
      cf_ff0 = Ff0Reset; cf_ff1 = 0; cf_ff2 = 0; cf_fb1 = 0; cf_fb2 = 0;
      cf_gain = GainReset;
      clear_hist();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset coefficients, field extremes, sign bit patterns
      sample_queue = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h5555,
                       16'haaaa, 16'h0100, 16'hff00};
      wait_idle();

      // extreme coefficients and max gain: saturation both ways
      load_coefs(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 16'hffff);
      sample_queue = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0003, 16'hfffd};
      wait_idle();
      // rewrite unchanged coefficient still clears history
      csr_write(RegFf1, 24'h7fffff);
      // unknown register index is ignored
      csr_write(3'd6, 24'h123456);
      csr_write(3'd7, 24'hffffff);
      // gain write keeps history
      csr_write(RegGain, 16'h0000);
      sample_queue = '{16'h1234, 16'h8000, 16'h7fff};
      wait_idle();
      csr_write(RegGain, 16'h1000);
      sample_queue = '{16'hedcb, 16'h0001};
      wait_idle();

      // random phases, each with its own coefficient set
      for (ph = 0; ph < 14; ph++) begin
         if (ph % 4 == 3)
            load_coefs(rand_coef(8388607), rand_coef(8388607), rand_coef(8388607),
                       rand_coef(8388607), rand_coef(8388607), 16'($urandom));
         else   // mostly stable-ish filters so the recursion stays in range
            load_coefs(rand_coef(1 << 20), rand_coef(1 << 21), rand_coef(1 << 20),
                       rand_coef(1 << 21), rand_coef(900000),
                       16'($urandom_range(0, 16384)));
         for (int k = 0; k < 100; k++) sample_queue.push_back(rand_sample());
         if (ph == 5) begin
            // hold off the receiver while the sender keeps offering words
            long_hold = 1'b1;
            repeat (2000) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_idle();
      end

      $display("Sent %0d words, checked %0d outputs, %0d register writes",
               n_sent, n_checked, n_cfg);
      $display("Covered sample extremes, coefficient extremes, saturation, history clears");
      if (n_errors == 0 && out_expected.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### files.f
design/bqf_pkg.sv
design/bqf_serial_mul.sv
design/biquad_iir_filter.sv
design/bqf_checker.sv
tb/biquad_iir_filter_tb.sv
